>>> hw/rtl/spm_pkg.sv
// Shared types and constants of the sample playback mixer.
`default_nettype none
package spm_pkg;
    localparam int SPM_NUM_CHANNELS = 4;
    localparam int SPM_ADDR_BITS    = 16;
    localparam int SPM_POS_W        = 24;
    localparam int SPM_RATE_W       = 17;
    localparam logic [SPM_RATE_W-1:0] SPM_RATE_RESET = 17'd44100;

    typedef enum logic [2:0] {
        FN_TICK    = 3'd0,
        FN_PLAY    = 3'd1,
        FN_STOP    = 3'd2,
        FN_VOL     = 3'd3,
        FN_STOPALL = 3'd4,
        FN_WRITE   = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    // one channel's playback record
    typedef struct packed {
        logic                 active;
        logic [7:0]           volume;
        logic [SPM_POS_W-1:0] pos;
        logic [SPM_POS_W-1:0] step;
        logic [15:0]          start;
        logic [15:0]          len;
        logic [15:0]          lstart;
        logic [15:0]          llen;
    } chan_rec_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic stop;
        logic set_vol;
    } cell_ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/spm_cell.sv
// One channel cell of the rotating channel ring.
`default_nettype none
module spm_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spm_pkg::cell_ctl_t ctl,
    input  wire spm_pkg::chan_rec_t shift_in,
    input  wire spm_pkg::chan_rec_t load_rec,
    input  wire logic [7:0]        vol,
    output spm_pkg::chan_rec_t     rec
);
    import spm_pkg::*;

    chan_rec_t rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            priority if (ctl.shift)
            begin
                rec_reg <= shift_in;
            end
            else if (ctl.load)
            begin
                rec_reg <= load_rec;
            end
            else if (ctl.stop)
            begin
                rec_reg.active <= 1'b0;
            end
            else if (ctl.set_vol)
            begin
                rec_reg.volume <= vol;
            end
        end
    end

    assign rec = rec_reg;
endmodule
`default_nettype wire

>>> hw/rtl/spm_div.sv
// Restoring divider for the channel step, one quotient bit per cycle.
`default_nettype none
module spm_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [spm_pkg::SPM_POS_W-1:0]  dividend,
    input  wire logic [spm_pkg::SPM_RATE_W-1:0] divisor,
    output logic                                done,
    output logic [spm_pkg::SPM_POS_W-1:0]       quotient
);
    import spm_pkg::*;

    logic                  busy_reg, busy_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [SPM_POS_W-1:0]  q_reg, q_next;
    logic [SPM_RATE_W-1:0] rem_reg, rem_next;
    logic [SPM_RATE_W-1:0] div_reg;
    logic [SPM_RATE_W:0]   trial;
    logic                  zero_div;

    assign trial    = {rem_reg, q_reg[SPM_POS_W-1]};
    assign zero_div = (div_reg == '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = SPM_RATE_W'(trial - {1'b0, div_reg});
                q_next   = {q_reg[SPM_POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SPM_RATE_W-1:0];
                q_next   = {q_reg[SPM_POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(SPM_POS_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = busy_reg && (cnt_reg == 5'(SPM_POS_W - 1));
    // a zero rate leaves the channel parked
    assign quotient = zero_div ? '0 : q_next;
endmodule
`default_nettype wire

>>> hw/rtl/sample_playback_mixer.sv
// Sample playback mixer top level: command decode, channel ring and mix datapath.
// Commands other than tick and play finish in the cycle they are taken. A play
// command for a valid channel holds the input until the bit-serial step divider is done.
// A tick walks the channel ring past the single mix head: an idle or stopping
// channel passes through ST_RD1 only, an active one through ST_RD1, ST_RD2,
// ST_MUL and ST_ACC (two reads of the one sample memory port, multiply,
// accumulate), and ST_FIN then posts the mixed word; the post also waits
// while the previous word is still unread. Memory contents are undefined until
// written.
`default_nettype none
module sample_playback_mixer #(
    parameter int NUM_CHANNELS     = spm_pkg::SPM_NUM_CHANNELS,
    parameter int SAMPLE_ADDR_BITS = spm_pkg::SPM_ADDR_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [16:0]  cfg_wdata,   // output_sample_rate
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // channel[1:0] address[17:2] sample_byte[25:18] length[41:26]
    // loop_start[57:42] loop_length[73:58] freq[89:74] volume[97:90]
    input  wire logic [103:0] s_tdata,
    input  wire logic [2:0]   s_tuser,     // func[2:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata      // mixed_sample[7:0] active_mask[11:8]
);
    import spm_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AW = SAMPLE_ADDR_BITS;

    state_t state_reg, state_next;

    logic [SPM_RATE_W-1:0] rate_reg;
    logic [103:0]          cmd_reg;
    logic [CW-1:0]         cnt_reg;
    logic signed [7:0]     acc_reg;
    logic signed [7:0]     b1_reg;
    logic signed [16:0]    prod1_reg, prod2_reg;
    logic [7:0]            rd_data_reg;
    logic [7:0]            mem [0:(1<<AW)-1];
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;

    func_t     func;
    logic      accept;
    logic      ch_ok;
    logic [1:0] ch_in;
    chan_rec_t recs [NUM_CHANNELS];
    cell_ctl_t ctls [NUM_CHANNELS];
    chan_rec_t head, upd, play_rec;
    logic [SPM_POS_W-1:0] div_q;
    logic      div_start, div_done;
    logic      rotate, last_ch, out_free;
    logic [3:0] mask;

    assign func     = func_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign ch_in    = s_tdata[1:0];
    assign ch_ok    = (32'(ch_in) < NUM_CHANNELS);
    assign last_ch  = (cnt_reg == CW'(NUM_CHANNELS - 1));
    assign out_free = !out_valid_reg || m_tready;
    assign head     = recs[0];

    // head channel decision
    logic [15:0] p1;
    logic [7:0]  frac;
    logic        looping, wrap, stop_ch;
    logic [16:0] last17, p2;
    logic [AW-1:0] rd_addr;
    logic [AW+17:0] a1_wide, a2_wide;

    assign frac    = head.pos[7:0];
    assign p1      = head.pos[SPM_POS_W-1:8];
    assign looping = (head.llen != '0);
    assign last17  = {1'b0, head.lstart} + {1'b0, head.llen} - 17'd1;
    assign wrap    = looping && ({1'b0, p1} >= last17);
    assign stop_ch = !looping && (({1'b0, p1} + 17'd1) >= {1'b0, head.len});
    assign p2      = wrap ? {1'b0, head.lstart} : {1'b0, p1} + 17'd1;
    assign a1_wide = (AW+18)'(head.start) + (AW+18)'(p1);
    assign a2_wide = (AW+18)'(head.start) + (AW+18)'(p2);
    assign rd_addr = (state_reg == ST_RD2) ? a2_wide[AW-1:0] : a1_wide[AW-1:0];

    always_comb
    begin
        upd     = head;
        upd.pos = wrap ? {head.lstart, 8'h00} : head.pos + head.step;
        if (stop_ch)
        begin
            upd.active = 1'b0;
        end
    end

    always_comb
    begin
        play_rec        = '0;
        play_rec.active = 1'b1;
        play_rec.volume = cmd_reg[97:90];
        play_rec.start  = cmd_reg[17:2];
        play_rec.len    = cmd_reg[41:26];
        play_rec.lstart = cmd_reg[57:42];
        play_rec.llen   = cmd_reg[73:58];
        play_rec.step   = div_q;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FN_TICK)
                begin
                    state_next = ST_RD1;
                end
                else if (accept && func == FN_PLAY && ch_ok)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD1:
            begin
                if (!head.active || stop_ch)
                begin
                    state_next = last_ch ? ST_FIN : ST_RD1;
                end
                else
                begin
                    state_next = ST_RD2;
                end
            end
            ST_RD2: state_next = ST_MUL;
            ST_MUL: state_next = ST_ACC;
            ST_ACC: state_next = last_ch ? ST_FIN : ST_RD1;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready  = 1'b0;
        rotate    = 1'b0;
        div_start = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            ctls[i] = '0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = accept && func == FN_PLAY && ch_ok;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    ctls[i].stop    = accept && ((func == FN_STOP && 32'(ch_in) == i)
                                      || func == FN_STOPALL);
                    ctls[i].set_vol = accept && func == FN_VOL && 32'(ch_in) == i;
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    ctls[i].load = div_done && 32'(cmd_reg[1:0]) == i;
                end
            end
            ST_RD1:   rotate = !head.active || stop_ch;
            ST_ACC:   rotate = 1'b1;
            ST_RD2, ST_MUL, ST_FIN: rotate = 1'b0;
            default:  rotate = 1'b0;
        endcase
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            ctls[i].shift = rotate;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++)
        begin : g_cell
            chan_rec_t nb;
            if (g == NUM_CHANNELS - 1)
            begin : g_tail
                // an idle channel goes round unchanged
                assign nb = head.active ? upd : head;
            end
            else
            begin : g_mid
                assign nb = recs[g+1];
            end
            spm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctls[g]),
                .shift_in (nb),
                .load_rec (play_rec),
                .vol      (s_tdata[97:90]),
                .rec      (recs[g])
            );
        end
        for (g = 0; g < 4; g++)
        begin : g_mask
            if (g < NUM_CHANNELS)
            begin : g_on
                assign mask[g] = recs[g].active;
            end
            else
            begin : g_off
                assign mask[g] = 1'b0;
            end
        end
    endgenerate

    spm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({s_tdata[89:74], 8'h00}),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // mix arithmetic
    logic signed [17:0] s_sum;
    logic signed [7:0]  bval;
    logic signed [16:0] scaled;
    logic signed [16:0] scaled_adj;
    logic signed [10:0] contrib, acc_sum;
    logic signed [7:0]  acc_clamped;

    assign s_sum      = 18'(prod1_reg) + 18'(prod2_reg);
    assign bval       = s_sum[15:8];
    assign scaled     = bval * $signed({1'b0, head.volume});
    assign scaled_adj = scaled[16] ? scaled + 17'sd63 : scaled;
    assign contrib    = 11'(scaled_adj >>> 6);
    assign acc_sum    = 11'(acc_reg) + contrib;

    always_comb
    begin
        priority if (acc_sum < -11'sd128)
        begin
            acc_clamped = -8'sd128;
        end
        else if (acc_sum > 11'sd127)
        begin
            acc_clamped = 8'sd127;
        end
        else
        begin
            acc_clamped = acc_sum[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= SPM_RATE_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
            if (state_reg == ST_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if (rotate)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tdata;
        end
        if (state_reg == ST_IDLE)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_clamped;
        end
        if (state_reg == ST_RD2)
        begin
            b1_reg <= rd_data_reg;
        end
        if (state_reg == ST_MUL)
        begin
            prod1_reg <= b1_reg * $signed({1'b0, 8'hFF - frac});
            prod2_reg <= $signed(rd_data_reg) * $signed({1'b0, frac});
        end
        if (state_reg == ST_FIN && out_free)
        begin
            out_data_reg <= {4'h0, mask, acc_reg};
        end
    end

    // sample memory, one read and at most one write per cycle
    always_ff @(posedge clk)
    begin
        if (accept && func == FN_WRITE)
        begin
            mem[AW'((AW+16)'(s_tdata[17:2]))] <= s_tdata[25:18];
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule
`default_nettype wire

>>> hw/rtl/spm_checker.sv
// Port-level checks of the sample playback mixer and their binding.
`default_nettype none
module spm_port_checks (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [2:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [15:0]  m_tdata
);
    import spm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FN_TICK |=> !s_tready)
        else $error("tick did not occupy the mixer");

    a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output word without a tick in progress");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'h0)
        else $error("output padding not zero");
endmodule

bind sample_playback_mixer spm_port_checks u_spm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
